>>> rtl/daps_pkg.sv
// ----------------------------------------------------------------------------
// daps_pkg
// Shared widths, payload structs, register indexes and the controller to
// datapath command and status types of the delay-aware multipath scheduler.
// ----------------------------------------------------------------------------
package daps_pkg;

	localparam int PATHS_DEF  = 8;
	localparam int PFIELD_W   = 3;
	localparam int RTT_W      = 24;
	localparam int WIN_W      = 16;
	localparam int SMW_W      = 20;
	localparam int SEQ_W      = 32;
	localparam int SEG_W      = 16;
	localparam int BUD_W      = 17;
	localparam int HALF_W     = 20;
	localparam int DLY_W      = 21;
	localparam int SLOT_W     = 33;
	localparam int END_W      = 32;
	localparam int DUE_W      = 34;
	localparam int PROD_W     = END_W + DLY_W;
	localparam int BASE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ROUND_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANNED    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH     = 2'd2;

	localparam logic [BASE_W-1:0] ROUND_BASE_RST = 8'd4;
	localparam logic [BUD_W-1:0]  BUD_UNSET      = '1;
	localparam logic [END_W-1:0]  END_SAT        = '1;

	localparam logic CMD_UPDATE  = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	typedef struct packed {
		logic                command;
		logic [PFIELD_W-1:0] path;
		logic [RTT_W-1:0]    rtt_value;
		logic [WIN_W-1:0]    window;
		logic                usable;
		logic [SEQ_W-1:0]    acked_seq;
		logic [SEQ_W-1:0]    sent_seq;
		logic [SEG_W-1:0]    segs_wanted;
	} in_item_t;

	typedef struct packed {
		logic                granted;
		logic [PFIELD_W-1:0] chosen_path;
		logic [SEG_W-1:0]    granted_segs;
		logic                by_fallback;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_UPDATE,
		OP_W_INIT,
		OP_P1_DIV,
		OP_P1_STEP,
		OP_P2_STEP,
		OP_W_FINISH,
		OP_B_INIT,
		OP_B_RANK,
		OP_B_ENTRY,
		OP_B_DELAY,
		OP_G_DIV,
		OP_G_STEP,
		OP_L_DIV,
		OP_L_MUL,
		OP_L_SAT,
		OP_B_NEXT,
		OP_B_FINISH,
		OP_FB_INIT,
		OP_FB_STEP,
		OP_FB_OUT
	} dp_op_t;

	typedef struct packed {
		logic div_done;
		logic is_req;
		logic walk_empty;
		logic best_v;
		logic k_last;
		logic p_last;
		logic sched_empty;
		logic need_round;
		logic lcm_skip;
		logic rem_zero;
	} dp_stat_t;

endpackage

>>> rtl/daps_div.sv
// ----------------------------------------------------------------------------
// daps_div
// Restoring divider, one quotient bit per cycle. Quotient and remainder hold
// until the next start; done pulses for one cycle.
// ----------------------------------------------------------------------------
module daps_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			// keep the trial remainder when the subtraction would go negative
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

>>> rtl/daps_dp.sv
// ----------------------------------------------------------------------------
// daps_dp
// Datapath: per-path statistics, schedule table, slot walk registers, LCM
// build, fallback search and the result register. Driven one op a cycle.
// ----------------------------------------------------------------------------
module daps_dp import daps_pkg::*; #(
	parameter int PATHS = PATHS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_item_t              in_item,
	input  dp_op_t                op,
	output dp_stat_t              stat,
	output logic                  done,
	output out_item_t             result
);

	localparam int IW    = $clog2(PATHS);
	localparam int CW    = $clog2(PATHS + 1);
	localparam int SMX_W = SMW_W + 1;

	// configuration
	logic [BASE_W-1:0] base_q;
	logic              planned_q;
	logic              smooth_en_q;

	// item being served
	in_item_t          item_q;
	logic [SEG_W-1:0]  want_q;

	// per-path state
	logic [RTT_W-1:0]  rtt_q  [PATHS];
	logic [WIN_W-1:0]  win_q  [PATHS];
	logic              use_q  [PATHS];
	logic [SMW_W-1:0]  smw_q  [PATHS];
	logic [SEQ_W-1:0]  mark_q [PATHS];
	logic [BUD_W-1:0]  bud_q  [PATHS];

	// schedule table
	logic [IW-1:0]     spath_q [PATHS];
	logic [WIN_W-1:0]  swin_q  [PATHS];
	logic [DLY_W-1:0]  sdly_q  [PATHS];
	logic [DUE_W-1:0]  fdue_q  [PATHS];
	logic [CW-1:0]     scount_q;
	logic [SLOT_W-1:0] slot_time_q;
	logic [IW-1:0]     slot_idx_q;
	logic [END_W-1:0]  slot_end_q;

	// walk and build working registers
	logic [IW-1:0]     k_q;
	logic [IW-1:0]     p_q;
	logic              best_v_q;
	logic [IW-1:0]     best_q;
	logic [DUE_W-1:0]  best_t_q;
	logic [END_W-1:0]  lcm_q;
	logic              sat_q;
	logic [END_W-1:0]  ga_q;
	logic [DLY_W-1:0]  gb_q;
	logic [DLY_W-1:0]  dly_q;
	logic [PROD_W-1:0] prod_q;
	logic              fb_v_q;
	logic [IW-1:0]     fb_p_q;
	logic [RTT_W-1:0]  fb_rtt_q;

	logic              done_q;
	out_item_t         res_q;

	// combinational
	logic [IW-1:0]     sk;
	logic [IW-1:0]     sp;
	logic [IW-1:0]     upd_p;
	logic              upd_ok;
	logic [IW-1:0]     rd_p;
	logic [WIN_W-1:0]  stab_w;
	logic [HALF_W-1:0] half;
	logic [DLY_W-1:0]  rnd_dly;
	logic [BASE_W-1:0] rem8;
	logic [PATHS-1:0]  elig;
	logic [CW-1:0]     rank;
	logic              div_start;
	logic [SLOT_W-1:0] div_num;
	logic [DLY_W-1:0]  div_den;
	logic              div_done;
	logic [SLOT_W-1:0] div_quot;
	logic [DLY_W-1:0]  div_rem;
	logic [DUE_W-1:0]  f_new;
	logic [DUE_W-1:0]  g_new;
	logic              g_take;
	logic              p2_clear;
	logic [BUD_W-1:0]  b0;
	logic [SEG_W-1:0]  gsegs;
	logic [SEQ_W-1:0]  seq_diff;
	logic [SMX_W-1:0]  s_sum;
	logic [SMW_W-1:0]  s_new;
	logic              s_upd;
	logic              k_last;

	assign sk    = (op == OP_W_FINISH) ? best_q : k_q;
	assign sp    = spath_q[sk];
	assign upd_p = IW'(item_q.path);
	assign upd_ok = (32'(item_q.path) < PATHS);

	always_comb begin
		case (op)
			OP_UPDATE:                          rd_p = upd_p;
			OP_B_RANK, OP_FB_STEP:              rd_p = p_q;
			default:                            rd_p = sp;
		endcase
	end

	// stable window of the selected path
	always_comb begin
		if (smooth_en_q && smw_q[rd_p] != '0)
			stab_w = smw_q[rd_p][SMW_W-2:3];
		else
			stab_w = win_q[rd_p];
		if (stab_w == '0)
			stab_w = WIN_W'(1);
	end

	// half RTT rounded to the base, at least one
	assign half = rtt_q[rd_p][RTT_W-1:4];
	assign rem8 = div_rem[BASE_W-1:0];
	always_comb begin
		if (base_q > BASE_W'(1)) begin
			if (rem8 < (base_q >> 1))
				rnd_dly = DLY_W'(half) - DLY_W'(rem8);
			else
				rnd_dly = DLY_W'(half) + DLY_W'(base_q) - DLY_W'(rem8);
		end else begin
			rnd_dly = DLY_W'(half);
		end
		if (rnd_dly == '0)
			rnd_dly = DLY_W'(1);
	end

	// rank of path p_q among eligible paths: RTT, then index
	always_comb begin
		rank = '0;
		for (int q = 0; q < PATHS; q++) begin
			elig[q] = use_q[q] && (rtt_q[q] != '0);
			if (elig[q] && ((rtt_q[q] < rtt_q[p_q]) ||
					(rtt_q[q] == rtt_q[p_q] && IW'(q) < p_q)))
				rank = rank + CW'(1);
		end
	end

	// shared divider operands
	always_comb begin
		div_start = 1'b0;
		div_num   = slot_time_q;
		div_den   = sdly_q[sk];
		case (op)
			OP_P1_DIV: begin
				div_start = 1'b1;
			end
			OP_B_ENTRY: begin
				div_start = (base_q > BASE_W'(1));
				div_num   = SLOT_W'(half);
				div_den   = DLY_W'(base_q);
			end
			OP_G_DIV: begin
				div_start = 1'b1;
				div_num   = SLOT_W'(ga_q);
				div_den   = gb_q;
			end
			OP_L_DIV: begin
				div_start = 1'b1;
				div_num   = SLOT_W'(lcm_q);
				div_den   = ga_q[DLY_W-1:0];
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	daps_div #(
		.NUM_W(SLOT_W),
		.DEN_W(DLY_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	// first due slot of schedule entry k and the walk candidate
	always_comb begin
		if (k_q >= slot_idx_q && div_rem == '0)
			f_new = DUE_W'(slot_time_q);
		else
			f_new = DUE_W'(slot_time_q) - DUE_W'(div_rem) + DUE_W'(sdly_q[k_q]);
		g_new = f_new;
		if (bud_q[sp] == '0)
			g_new = f_new + DUE_W'(sdly_q[k_q]);
		g_take = use_q[sp] && (g_new <= DUE_W'(slot_end_q)) &&
			(!best_v_q || g_new < best_t_q);
	end

	always_comb begin
		p2_clear = (fdue_q[k_q] <= DUE_W'(slot_end_q)) &&
			(!best_v_q || fdue_q[k_q] < best_t_q ||
			(fdue_q[k_q] == best_t_q && k_q < best_q)) &&
			(!use_q[sp] || bud_q[sp] == '0);
	end

	// budget at the granted entry, then the grant
	always_comb begin
		if (bud_q[sp] == BUD_UNSET)
			b0 = BUD_W'(planned_q ? swin_q[best_q] : stab_w);
		else
			b0 = bud_q[sp];
		if (BUD_W'(want_q) < b0)
			gsegs = want_q;
		else
			gsegs = b0[SEG_W-1:0];
	end

	// smoothed window update
	always_comb begin
		seq_diff = item_q.acked_seq - mark_q[upd_p];
		s_upd    = smooth_en_q && item_q.usable && (item_q.window != '0) &&
			!seq_diff[SEQ_W-1];
		if (smw_q[upd_p] != '0)
			s_sum = SMX_W'(smw_q[upd_p]) + SMX_W'(item_q.window) -
				SMX_W'(smw_q[upd_p] >> 3);
		else
			s_sum = SMX_W'(item_q.window) << 3;
		s_new = s_sum[SMW_W-1:0];
		if (s_new == '0)
			s_new = SMW_W'(1);
	end

	assign k_last = (CW'(k_q) + CW'(1) == scount_q);

	always_comb begin
		stat.div_done    = div_done;
		stat.is_req      = (item_q.command == CMD_REQUEST);
		stat.walk_empty  = (scount_q == '0) || (slot_time_q > SLOT_W'(slot_end_q));
		stat.best_v      = best_v_q;
		stat.k_last      = k_last;
		stat.p_last      = (p_q == IW'(PATHS - 1));
		stat.sched_empty = (scount_q == '0);
		stat.need_round  = (base_q > BASE_W'(1));
		stat.lcm_skip    = (k_q == '0) || sat_q;
		stat.rem_zero    = (div_rem == '0);
	end

	// configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= ROUND_BASE_RST;
			planned_q   <= 1'b1;
			smooth_en_q <= 1'b1;
			for (int i = 0; i < PATHS; i++) begin
				rtt_q[i]  <= '0;
				win_q[i]  <= '0;
				use_q[i]  <= 1'b0;
				smw_q[i]  <= '0;
				mark_q[i] <= '0;
				bud_q[i]  <= BUD_UNSET;
			end
			scount_q    <= '0;
			slot_time_q <= SLOT_W'(1);
			slot_idx_q  <= '0;
			slot_end_q  <= '0;
			k_q         <= '0;
			p_q         <= '0;
			best_v_q    <= 1'b0;
			best_q      <= '0;
			lcm_q       <= '0;
			sat_q       <= 1'b0;
			fb_v_q      <= 1'b0;
			fb_p_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROUND_BASE: base_q      <= cfg_data;
					CFG_PLANNED:    planned_q   <= cfg_data[0];
					CFG_SMOOTH:     smooth_en_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (op)
				OP_UPDATE: begin
					if (upd_ok) begin
						rtt_q[upd_p] <= item_q.rtt_value;
						win_q[upd_p] <= item_q.window;
						use_q[upd_p] <= item_q.usable;
						if (s_upd) begin
							smw_q[upd_p]  <= s_new;
							mark_q[upd_p] <= item_q.sent_seq;
						end
					end
					done_q <= 1'b1;
				end
				OP_W_INIT: begin
					k_q      <= '0;
					best_v_q <= 1'b0;
				end
				OP_P1_STEP: begin
					if (g_take) begin
						best_v_q <= 1'b1;
						best_q   <= k_q;
					end
					k_q <= k_last ? '0 : k_q + IW'(1);
				end
				OP_P2_STEP: begin
					if (p2_clear)
						bud_q[sp] <= BUD_UNSET;
					k_q <= k_last ? '0 : k_q + IW'(1);
				end
				OP_W_FINISH: begin
					if (!best_v_q) begin
						slot_time_q <= SLOT_W'(slot_end_q) + SLOT_W'(1);
						slot_idx_q  <= '0;
					end else begin
						bud_q[sp]   <= b0 - BUD_W'(gsegs);
						slot_time_q <= best_t_q[SLOT_W-1:0];
						slot_idx_q  <= best_q;
						done_q      <= 1'b1;
					end
				end
				OP_B_INIT: begin
					p_q      <= '0;
					k_q      <= '0;
					scount_q <= '0;
					lcm_q    <= '0;
					sat_q    <= 1'b0;
				end
				OP_B_RANK: begin
					if (elig[p_q]) begin
						bud_q[p_q] <= BUD_UNSET;
						scount_q   <= scount_q + CW'(1);
					end
					p_q <= stat.p_last ? '0 : p_q + IW'(1);
				end
				OP_B_DELAY: begin
					if (k_q == '0)
						lcm_q <= END_W'(rnd_dly);
				end
				OP_L_SAT: begin
					if (prod_q > PROD_W'(END_SAT)) begin
						lcm_q <= END_SAT;
						sat_q <= 1'b1;
					end else begin
						lcm_q <= prod_q[END_W-1:0];
					end
				end
				OP_B_NEXT: begin
					k_q <= k_q + IW'(1);
				end
				OP_B_FINISH: begin
					slot_time_q <= SLOT_W'(1);
					slot_idx_q  <= '0;
					slot_end_q  <= lcm_q;
				end
				OP_FB_INIT: begin
					p_q    <= '0;
					fb_v_q <= 1'b0;
				end
				OP_FB_STEP: begin
					if (use_q[p_q] && (!fb_v_q || rtt_q[p_q] < fb_rtt_q)) begin
						fb_v_q <= 1'b1;
						fb_p_q <= p_q;
					end
					p_q <= stat.p_last ? '0 : p_q + IW'(1);
				end
				OP_FB_OUT: begin
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LATCH: begin
				item_q <= in_item;
				want_q <= (in_item.segs_wanted == '0) ? SEG_W'(1) : in_item.segs_wanted;
			end
			OP_UPDATE: begin
				res_q <= '0;
			end
			OP_P1_STEP: begin
				fdue_q[k_q] <= f_new;
				if (g_take)
					best_t_q <= g_new;
			end
			OP_W_FINISH: begin
				res_q.granted      <= 1'b1;
				res_q.chosen_path  <= PFIELD_W'(sp);
				res_q.granted_segs <= gsegs;
				res_q.by_fallback  <= 1'b0;
			end
			OP_B_RANK: begin
				if (elig[p_q])
					spath_q[rank[IW-1:0]] <= p_q;
			end
			OP_B_ENTRY: begin
				swin_q[k_q] <= stab_w;
			end
			OP_B_DELAY: begin
				sdly_q[k_q] <= rnd_dly;
				dly_q       <= rnd_dly;
				ga_q        <= lcm_q;
				gb_q        <= rnd_dly;
			end
			OP_G_STEP: begin
				ga_q <= END_W'(gb_q);
				gb_q <= div_rem;
			end
			OP_L_MUL: begin
				prod_q <= PROD_W'(div_quot[END_W-1:0]) * PROD_W'(dly_q);
			end
			OP_FB_STEP: begin
				if (use_q[p_q] && (!fb_v_q || rtt_q[p_q] < fb_rtt_q))
					fb_rtt_q <= rtt_q[p_q];
			end
			OP_FB_OUT: begin
				if (fb_v_q) begin
					res_q.granted      <= 1'b1;
					res_q.chosen_path  <= PFIELD_W'(fb_p_q);
					res_q.granted_segs <= want_q;
					res_q.by_fallback  <= 1'b1;
				end else begin
					res_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> rtl/daps_ctrl.sv
// ----------------------------------------------------------------------------
// daps_ctrl
// Sequencer: update, schedule walk, rebuild with LCM, second walk and
// minimum-RTT fallback, issued as one datapath op per cycle, none while it waits on the divider.
// ----------------------------------------------------------------------------
module daps_ctrl import daps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_op_t   op,
	output logic     busy
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_W_START,
		S_P1_DIV,
		S_P1_WAIT,
		S_P2,
		S_W_END,
		S_B_INIT,
		S_B_RANK,
		S_B_CHK,
		S_B_ENTRY,
		S_B_RWAIT,
		S_G_DIV,
		S_G_WAIT,
		S_L_DIV,
		S_L_WAIT,
		S_L_SAT,
		S_B_NEXT,
		S_B_FINISH,
		S_FB_INIT,
		S_FB_SCAN,
		S_FB_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   second_q;

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op      = OP_LATCH;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_req) begin
					state_d = S_W_START;
				end else begin
					op      = OP_UPDATE;
					state_d = S_IDLE;
				end
			end
			S_W_START: begin
				if (stat.walk_empty) begin
					state_d = second_q ? S_FB_INIT : S_B_INIT;
				end else begin
					op      = OP_W_INIT;
					state_d = S_P1_DIV;
				end
			end
			S_P1_DIV: begin
				op      = OP_P1_DIV;
				state_d = S_P1_WAIT;
			end
			S_P1_WAIT: begin
				if (stat.div_done) begin
					op      = OP_P1_STEP;
					state_d = stat.k_last ? S_P2 : S_P1_DIV;
				end
			end
			S_P2: begin
				op = OP_P2_STEP;
				if (stat.k_last)
					state_d = S_W_END;
			end
			S_W_END: begin
				op = OP_W_FINISH;
				if (stat.best_v)
					state_d = S_IDLE;
				else
					state_d = second_q ? S_FB_INIT : S_B_INIT;
			end
			S_B_INIT: begin
				op      = OP_B_INIT;
				state_d = S_B_RANK;
			end
			S_B_RANK: begin
				op = OP_B_RANK;
				if (stat.p_last)
					state_d = S_B_CHK;
			end
			S_B_CHK: begin
				state_d = stat.sched_empty ? S_B_FINISH : S_B_ENTRY;
			end
			S_B_ENTRY: begin
				op      = OP_B_ENTRY;
				state_d = S_B_RWAIT;
			end
			S_B_RWAIT: begin
				if (!stat.need_round || stat.div_done) begin
					op      = OP_B_DELAY;
					state_d = stat.lcm_skip ? S_B_NEXT : S_G_DIV;
				end
			end
			S_G_DIV: begin
				op      = OP_G_DIV;
				state_d = S_G_WAIT;
			end
			S_G_WAIT: begin
				if (stat.div_done) begin
					op      = OP_G_STEP;
					state_d = stat.rem_zero ? S_L_DIV : S_G_DIV;
				end
			end
			S_L_DIV: begin
				op      = OP_L_DIV;
				state_d = S_L_WAIT;
			end
			S_L_WAIT: begin
				if (stat.div_done) begin
					op      = OP_L_MUL;
					state_d = S_L_SAT;
				end
			end
			S_L_SAT: begin
				op      = OP_L_SAT;
				state_d = S_B_NEXT;
			end
			S_B_NEXT: begin
				op      = OP_B_NEXT;
				state_d = stat.k_last ? S_B_FINISH : S_B_ENTRY;
			end
			S_B_FINISH: begin
				op      = OP_B_FINISH;
				state_d = S_W_START;
			end
			S_FB_INIT: begin
				op      = OP_FB_INIT;
				state_d = S_FB_SCAN;
			end
			S_FB_SCAN: begin
				op = OP_FB_STEP;
				if (stat.p_last)
					state_d = S_FB_OUT;
			end
			S_FB_OUT: begin
				op      = OP_FB_OUT;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// mark the walk after a rebuild as the last one
			if (state_q == S_IDLE)
				second_q <= 1'b0;
			else if (state_q == S_B_FINISH)
				second_q <= 1'b1;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/delay_aware_multipath_scheduler_core.sv
// ----------------------------------------------------------------------------
// delay_aware_multipath_scheduler_core
// Delay-aware multipath segment scheduler: path statistics and slot walk.
// ----------------------------------------------------------------------------
// Usage: drive in_item and raise start; the transaction is taken at an edge
// with start high and busy low. command 0 updates one path's statistics,
// command 1 asks for a segment grant. Each transaction yields one result on
// result, shown for a single cycle with done high; the receiver cannot stall
// it, so capture it then. busy falls in the cycle done is shown, so the next
// transaction may be taken there.
// A request walks the schedule through one shared divider. A walk that finds
// nothing rebuilds the table: a ranking pass over the paths, then per entry
// delay rounding, Euclid steps and an LCM fold as needed, then a second
// walk; a failed second walk ends in a fallback search. Transactions do
// not overlap.
// Reset: statistics zero, budgets unset, schedule empty, registers at their
// defaults; no clearing pass. cfg_we writes the register named by cfg_index.
// ----------------------------------------------------------------------------
module delay_aware_multipath_scheduler_core import daps_pkg::*; #(
	parameter int PATHS = PATHS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              in_item,
	output logic                  done,
	output out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_op_t   op;
	dp_stat_t stat;

	daps_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.op    (op),
		.busy  (busy)
	);

	daps_dp #(
		.PATHS(PATHS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_item  (in_item),
		.op       (op),
		.stat     (stat),
		.done     (done),
		.result   (result)
	);

endmodule

>>> rtl/daps_chk.sv
// ----------------------------------------------------------------------------
// daps_chk
// Port-level checks of the scheduler's transaction sequencing and results.
// ----------------------------------------------------------------------------
module daps_chk import daps_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_item_t result
);

	// an accepted transaction keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after an accepted transaction");

	// a result only ends a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result without a transaction in progress");

	// no grant means an all-zero result
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.granted |-> result == '0)
		else $error("non-zero fields on a result without grant");

	// a grant always allows at least one segment
	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.granted |-> result.granted_segs != '0)
		else $error("grant of zero segments");

endmodule

bind delay_aware_multipath_scheduler_core daps_chk u_daps_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delay-aware multipath scheduler core. Update and
// request transactions are queued, driven under varying idle patterns, and
// every result is checked against a cycle-free model of paths and schedule.
// ----------------------------------------------------------------------------
module tb;
	import daps_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	in_item_t              in_item;
	logic                  done;
	out_item_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	delay_aware_multipath_scheduler_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// model state
	logic [7:0]  m_base;
	logic        m_planned, m_smooth;
	logic [23:0] m_rtt [8];
	logic [15:0] m_win [8];
	logic        m_usable [8];
	logic [19:0] m_smw [8];
	logic [31:0] m_mark [8];
	int          m_budget [8];
	int unsigned m_spath [8];
	int unsigned m_swin [8];
	longint unsigned m_sdly [8];
	int unsigned m_scount, m_sidx;
	longint unsigned m_stime, m_send;

	in_item_t  pending_q [$];
	out_item_t grant_q [$];
	int        errors, n_results, n_fallback, n_sched;
	int        send_idle_pct;
	bit        hold_send;

	function automatic int unsigned stable_win(int unsigned p);
		int unsigned w;
		w = m_win[p];
		if (m_smooth && m_smw[p] != 0) w = m_smw[p] >> 3;
		return w == 0 ? 1 : w;
	endfunction

	function automatic longint unsigned delay_of(int unsigned p);
		longint unsigned half, b, rem;
		half = (m_rtt[p] >> 3) / 2;
		b = m_base;
		if (b > 1) begin
			rem = half % b;
			if (rem < b / 2) half -= rem;
			else half += b - rem;
		end
		return half == 0 ? 1 : half;
	endfunction

	function automatic longint unsigned gcd(longint unsigned a, longint unsigned b);
		longint unsigned r;
		while (b != 0) begin
			r = a % b; a = b; b = r;
		end
		return a;
	endfunction

	function automatic void rebuild_schedule();
		int unsigned n, k;
		longint unsigned l;
		bit sat;
		n = 0; l = 0; sat = 0;
		for (int unsigned p = 0; p < 8; p++) begin
			if (!m_usable[p] || m_rtt[p] == 0) continue;
			m_budget[p] = -1;
			k = n;
			while (k > 0 && m_rtt[m_spath[k-1]] > m_rtt[p]) begin
				m_spath[k] = m_spath[k-1];
				k--;
			end
			m_spath[k] = p;
			n++;
		end
		for (k = 0; k < n; k++) begin
			m_swin[k] = stable_win(m_spath[k]);
			m_sdly[k] = delay_of(m_spath[k]);
			if (k == 0) l = m_sdly[k];
			else if (!sat) begin
				l = l / gcd(l, m_sdly[k]) * m_sdly[k];
				if (l > 64'hffffffff) begin
					l = 64'hffffffff; sat = 1;
				end
			end
		end
		m_scount = n; m_stime = 1; m_sidx = 0; m_send = l;
	endfunction

	function automatic longint unsigned first_due(int unsigned k, longint unsigned t0,
			int unsigned i0);
		longint unsigned d;
		d = m_sdly[k];
		if (k >= i0 && t0 % d == 0) return t0;
		return (t0 / d + 1) * d;
	endfunction

	function automatic int walk_slots();
		longint unsigned t0, e, best_t, g, f;
		int unsigned i0, p;
		int best;
		bit earlier;
		t0 = m_stime; e = m_send; i0 = m_sidx; best = -1; best_t = 0;
		if (m_scount == 0 || t0 > e) return -1;
		for (int unsigned k = 0; k < m_scount; k++) begin
			p = m_spath[k];
			if (!m_usable[p]) continue;
			g = first_due(k, t0, i0);
			if (m_budget[p] == 0) g += m_sdly[k];
			if (g <= e && (best < 0 || g < best_t)) begin
				best = int'(k); best_t = g;
			end
		end
		for (int unsigned k = 0; k < m_scount; k++) begin
			f = first_due(k, t0, i0);
			p = m_spath[k];
			if (f > e) continue;
			earlier = best < 0 || f < best_t || (f == best_t && int'(k) < best);
			if (!earlier) continue;
			if (!m_usable[p] || m_budget[p] == 0) m_budget[p] = -1;
		end
		if (best < 0) begin
			m_stime = e + 1; m_sidx = 0;
			return -1;
		end
		p = m_spath[best];
		if (m_budget[p] == -1)
			m_budget[p] = m_planned ? m_swin[best] : stable_win(p);
		m_stime = best_t; m_sidx = best;
		return best;
	endfunction

	function automatic out_item_t predict_grant(in_item_t it);
		out_item_t o;
		int unsigned p, w, want, g, s;
		int k, bestp;
		o = '0;
		if (it.command == CMD_UPDATE) begin
			p = it.path;
			w = it.window;
			m_rtt[p] = it.rtt_value; m_win[p] = it.window; m_usable[p] = it.usable;
			if (m_smooth && it.usable && w != 0 &&
					((it.acked_seq - m_mark[p]) & 32'h80000000) == 0) begin
				s = m_smw[p];
				s = (s != 0) ? s + w - (s >> 3) : w << 3;
				m_smw[p] = SMW_W'(s == 0 ? 1 : s);
				m_mark[p] = it.sent_seq;
			end
			return o;
		end
		want = it.segs_wanted == 0 ? 1 : it.segs_wanted;
		k = walk_slots();
		if (k < 0) begin
			rebuild_schedule();
			k = walk_slots();
		end
		if (k >= 0) begin
			p = m_spath[k];
			g = m_budget[p];
			if (want < g) g = want;
			m_budget[p] -= g;
			o.granted = 1'b1; o.chosen_path = PFIELD_W'(p); o.granted_segs = SEG_W'(g);
			return o;
		end
		bestp = -1;
		for (int q = 0; q < 8; q++)
			if (m_usable[q] && (bestp < 0 || m_rtt[q] < m_rtt[bestp])) bestp = q;
		if (bestp >= 0) begin
			o.granted = 1'b1; o.chosen_path = PFIELD_W'(bestp);
			o.granted_segs = SEG_W'(want); o.by_fallback = 1'b1;
		end
		return o;
	endfunction

	task automatic report(string what, int unsigned got, int unsigned exp);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			in_item <= '0;
		end else if (!(start && busy)) begin
			// previous transaction taken (or none offered)
			if (start) grant_q.push_back(predict_grant(in_item));
			if (pending_q.size() > 0 && !hold_send &&
					$urandom_range(99, 0) >= send_idle_pct) begin
				in_item <= pending_q.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && done) begin
			n_results++;
			if (grant_q.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				e = grant_q.pop_front();
				if (e.by_fallback) n_fallback++;
				else if (e.granted) n_sched++;
				if (result.granted !== e.granted) report("granted", result.granted, e.granted);
				if (result.chosen_path !== e.chosen_path)
					report("chosen_path", result.chosen_path, e.chosen_path);
				if (result.granted_segs !== e.granted_segs)
					report("granted_segs", result.granted_segs, e.granted_segs);
				if (result.by_fallback !== e.by_fallback)
					report("by_fallback", result.by_fallback, e.by_fallback);
			end
		end
	end

	function automatic in_item_t path_update(int unsigned p, int unsigned rtt,
			int unsigned win, bit use_it);
		in_item_t it;
		it = '0;
		it.command = CMD_UPDATE; it.path = PFIELD_W'(p); it.rtt_value = RTT_W'(rtt);
		it.window = WIN_W'(win);
		it.usable = use_it; it.acked_seq = $urandom(); it.sent_seq = $urandom();
		it.segs_wanted = SEG_W'($urandom());
		return it;
	endfunction

	function automatic in_item_t seg_request(int unsigned segs);
		in_item_t it;
		it = '0;
		it.command = CMD_REQUEST; it.path = PFIELD_W'($urandom());
		it.rtt_value = RTT_W'($urandom());
		it.window = WIN_W'($urandom()); it.usable = 1'($urandom());
		it.acked_seq = $urandom();
		it.sent_seq = $urandom(); it.segs_wanted = SEG_W'(segs);
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 55) return seg_request($urandom_range(9) == 0 ? $urandom() : $urandom_range(40, 0));
		it = path_update($urandom_range(7, 0), 0, 0, $urandom_range(9, 0) != 0);
		case ($urandom_range(5, 0))
			0: it.rtt_value = RTT_W'($urandom());
			1: it.rtt_value = '0;
			default: it.rtt_value = RTT_W'($urandom_range(800, 8));
		endcase
		it.window = WIN_W'($urandom_range(7, 0) == 0 ? $urandom() : $urandom_range(30, 0));
		// mostly advancing acks so the smoothed window keeps moving
		if ($urandom_range(3, 0) != 0) begin
			it.acked_seq = m_mark[it.path] + $urandom_range(100, 0);
			it.sent_seq = it.acked_seq + $urandom_range(200, 0);
		end
		return it;
	endfunction

	task automatic wait_drain();
		while (pending_q.size() > 0 || start || grant_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ROUND_BASE: m_base = val;
			CFG_PLANNED:    m_planned = val[0];
			CFG_SMOOTH:     m_smooth = val[0];
			default: ;
		endcase
	endtask

	task automatic run_phase(int idle, int n);
		send_idle_pct = idle;
		for (int i = 0; i < n; i++) pending_q.push_back(random_item());
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		hold_send = 0; errors = 0; n_results = 0; n_fallback = 0; n_sched = 0;
		send_idle_pct = 0;
		m_base = ROUND_BASE_RST; m_planned = 1; m_smooth = 1;
		m_scount = 0; m_stime = 1; m_sidx = 0; m_send = 0;
		for (int p = 0; p < 8; p++) begin
			m_rtt[p] = 0; m_win[p] = 0; m_usable[p] = 0; m_smw[p] = 0; m_mark[p] = 0;
			m_budget[p] = -1; m_spath[p] = 0; m_swin[p] = 0; m_sdly[p] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, zero segs, extremes, fallback, unusable paths
		pending_q.push_back(seg_request(0));
		pending_q.push_back(path_update(7, 24'hffffff, 16'hffff, 1));
		pending_q.push_back(path_update(0, 0, 5, 1));
		pending_q.push_back(seg_request(16'hffff));
		pending_q.push_back(path_update(1, 80, 3, 1));
		pending_q.push_back(path_update(2, 80, 2, 1));
		pending_q.push_back(path_update(3, 48, 0, 1));
		pending_q.push_back(path_update(4, 200, 4, 0));
		for (int i = 0; i < 10; i++) pending_q.push_back(seg_request(i % 3));
		pending_q.push_back(path_update(1, 80, 3, 0));
		pending_q.push_back(seg_request(1));
		pending_q.push_back(seg_request(16'hffff));
		// part way through, idle until all results are back
		while (pending_q.size() > 12) @(posedge clk);
		hold_send = 1;
		while (start || grant_q.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);
		hold_send = 0;
		wait_drain();

		write_reg(CFG_ROUND_BASE, 8'd0);
		write_reg(CFG_PLANNED, 8'd0);
		run_phase(0, 120);
		write_reg(CFG_ROUND_BASE, 8'd255);
		write_reg(CFG_SMOOTH, 8'd0);
		run_phase(86, 110);
		write_reg(CFG_ROUND_BASE, 8'd1);
		write_reg(CFG_PLANNED, 8'd1);
		run_phase(12, 110);
		write_reg(CFG_ROUND_BASE, 8'd3);
		write_reg(CFG_SMOOTH, 8'd1);
		run_phase(0, 100);
		write_reg(CFG_ROUND_BASE, 8'd4);
		run_phase(50, 90);

		$display("covered %0d results: %0d scheduled grants, %0d fallback grants",
			n_results, n_sched, n_fallback);
		$display("round base settings 0/1/3/4/255, both window modes, smoothing on and off");
		if (errors == 0) begin
			$display("PASS delay_aware_multipath_scheduler_core");
		end else begin
			$display("FAIL delay_aware_multipath_scheduler_core");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("FAIL delay_aware_multipath_scheduler_core");
		$finish;
	end

endmodule
